/* rtl/core/deft_pkg.sv */
package deft_pkg;

  // Table sizes and the stored parameter width.
  localparam int MsgCount   = 16;
  localparam int BcCount    = 8;
  localparam int ParamWidth = 16;

  // Fixed field widths of the stream items.
  localparam int OpWidth       = 3;
  localparam int IndexWidth    = 4;
  localparam int ParamInWidth  = 16;
  localparam int ParamOutWidth = 16;
  localparam int FlagWidth     = 2;

  // Index widths that address each table. The extended widths also hold the
  // table size itself, so the range check compares against an exact value.
  localparam int MsgIdxW = (MsgCount > 1) ? $clog2(MsgCount) : 1;
  localparam int BcIdxW  = (BcCount > 1) ? $clog2(BcCount) : 1;
  localparam int MsgExtW = (MsgIdxW + 1 > IndexWidth) ? MsgIdxW + 1 : IndexWidth;
  localparam int BcExtW  = (BcIdxW + 1 > IndexWidth) ? BcIdxW + 1 : IndexWidth;

  // Packed stream widths, rounded up to whole bytes.
  localparam int InFieldsW  = OpWidth + IndexWidth + ParamInWidth;
  localparam int OutFieldsW = 1 + ParamOutWidth;
  localparam int InDataW    = ((InFieldsW + 7) / 8) * 8;
  localparam int OutDataW   = ((OutFieldsW + 7) / 8) * 8;

  typedef enum logic [OpWidth-1:0] {
    OpSend      = 3'd0,
    OpSendParam = 3'd1,
    OpGet       = 3'd2,
    OpReadParam = 3'd3,
    OpTick      = 3'd4,
    OpBcSend    = 3'd5,
    OpBcGet     = 3'd6,
    OpClear     = 3'd7
  } op_e;

  typedef enum logic [FlagWidth-1:0] {
    FlagIdle    = 2'd0,
    FlagPosted  = 2'd1,
    FlagVisible = 2'd2
  } flag_e;

  typedef struct packed {
    logic [ParamInWidth-1:0] param_in;
    logic [IndexWidth-1:0]   message_index;
    op_e                     operation;
  } item_t;

  typedef struct packed {
    logic [ParamOutWidth-1:0] param_out;
    logic                     message_seen;
  } result_t;

  // One tick step of a flag; the unused code stays as it is.
  function automatic logic [FlagWidth-1:0] advance_flag(input logic [FlagWidth-1:0] f);
    logic [FlagWidth-1:0] nxt;
    nxt = f;
    if (f == FlagVisible) begin
      nxt = FlagIdle;
    end else if (f == FlagPosted) begin
      nxt = FlagVisible;
    end
    return nxt;
  endfunction

endpackage

/* rtl/core/deft_core.sv */
module deft_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             fire_i,
  input  deft_pkg::item_t  item_i,
  output deft_pkg::result_t result_o
);

  logic [deft_pkg::FlagWidth-1:0]  msg_flags_q [deft_pkg::MsgCount];
  logic [deft_pkg::ParamWidth-1:0] msg_params_q [deft_pkg::MsgCount];
  logic [deft_pkg::FlagWidth-1:0]  bc_flags_q [deft_pkg::BcCount];

  logic [deft_pkg::MsgExtW-1:0] msg_ext;
  logic [deft_pkg::BcExtW-1:0]  bc_ext;
  logic [deft_pkg::MsgIdxW-1:0] msg_sel;
  logic [deft_pkg::BcIdxW-1:0]  bc_sel;
  logic                         msg_ok;
  logic                         bc_ok;
  logic [deft_pkg::FlagWidth-1:0]  msg_flag;
  logic [deft_pkg::FlagWidth-1:0]  bc_flag;
  logic [deft_pkg::ParamWidth-1:0] msg_param;

  // Decode the addressed entry of each table.
  assign msg_ext = deft_pkg::MsgExtW'(item_i.message_index);
  assign bc_ext  = deft_pkg::BcExtW'(item_i.message_index);
  assign msg_ok  = msg_ext < deft_pkg::MsgExtW'(deft_pkg::MsgCount);
  assign bc_ok   = bc_ext < deft_pkg::BcExtW'(deft_pkg::BcCount);
  assign msg_sel = msg_ext[deft_pkg::MsgIdxW-1:0];
  assign bc_sel  = bc_ext[deft_pkg::BcIdxW-1:0];

  assign msg_flag  = msg_ok ? msg_flags_q[msg_sel] : deft_pkg::FlagIdle;
  assign bc_flag   = bc_ok ? bc_flags_q[bc_sel] : deft_pkg::FlagIdle;
  assign msg_param = msg_ok ? msg_params_q[msg_sel] : '0;

  // Result of the current item, taken from the state before its update.
  always_comb begin
    result_o = '0;
    unique case (item_i.operation)
      deft_pkg::OpGet: begin
        result_o.message_seen = msg_ok && (msg_flag == deft_pkg::FlagVisible);
      end
      deft_pkg::OpReadParam: begin
        result_o.param_out = deft_pkg::ParamOutWidth'(msg_param);
      end
      deft_pkg::OpBcGet: begin
        result_o.message_seen = bc_ok && (bc_flag == deft_pkg::FlagVisible);
      end
      deft_pkg::OpSend, deft_pkg::OpSendParam, deft_pkg::OpTick,
      deft_pkg::OpBcSend, deft_pkg::OpClear: begin
        result_o = '0;
      end
      default: begin
        result_o = '0;
      end
    endcase
  end

  // Message flags and stored parameters.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < deft_pkg::MsgCount; i++) begin
        msg_flags_q[i]  <= deft_pkg::FlagIdle;
        msg_params_q[i] <= '0;
      end
    end else if (fire_i) begin
      unique case (item_i.operation)
        deft_pkg::OpSend, deft_pkg::OpSendParam: begin
          if (msg_ok && msg_flag == deft_pkg::FlagIdle) begin
            msg_flags_q[msg_sel] <= deft_pkg::FlagPosted;
            if (item_i.operation == deft_pkg::OpSendParam) begin
              msg_params_q[msg_sel] <= deft_pkg::ParamWidth'(item_i.param_in);
            end
          end
        end
        deft_pkg::OpGet: begin
          if (msg_ok && msg_flag == deft_pkg::FlagVisible) begin
            msg_flags_q[msg_sel] <= deft_pkg::FlagIdle;
          end
        end
        deft_pkg::OpTick: begin
          for (int i = 0; i < deft_pkg::MsgCount; i++) begin
            msg_flags_q[i] <= deft_pkg::advance_flag(msg_flags_q[i]);
          end
        end
        deft_pkg::OpClear: begin
          for (int i = 0; i < deft_pkg::MsgCount; i++) begin
            msg_flags_q[i] <= deft_pkg::FlagIdle;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Broadcast flags; a broadcast get leaves the entry as it is.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < deft_pkg::BcCount; i++) begin
        bc_flags_q[i] <= deft_pkg::FlagIdle;
      end
    end else if (fire_i) begin
      unique case (item_i.operation)
        deft_pkg::OpBcSend: begin
          if (bc_ok && bc_flag == deft_pkg::FlagIdle) begin
            bc_flags_q[bc_sel] <= deft_pkg::FlagPosted;
          end
        end
        deft_pkg::OpTick: begin
          for (int i = 0; i < deft_pkg::BcCount; i++) begin
            bc_flags_q[i] <= deft_pkg::advance_flag(bc_flags_q[i]);
          end
        end
        deft_pkg::OpClear: begin
          for (int i = 0; i < deft_pkg::BcCount; i++) begin
            bc_flags_q[i] <= deft_pkg::FlagIdle;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

/* rtl/core/delayed_event_flag_table.sv */
// Event flag table for cooperating state machines. Each input transfer carries one
// operation (send, send with parameter, get, read parameter, tick, broadcast send,
// broadcast get, clear) and produces exactly one result transfer. An item passes
// through an input register and then a result register, and the flag and
// parameter tables update in the cycle the item moves between them, so one item
// is taken per cycle while the result side keeps accepting, and its result is
// offered on the master side once it has reached the result register. All table
// state lives in flip-flops; a tick updates every entry at once, in the cycle it
// moves between the registers. Reset clears both flag tables to idle and the
// stored parameters to zero at once, with no clearing pass.
module delayed_event_flag_table (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // Fields from bit 0: operation[2:0], message_index[6:3], param_in[22:7], zero fill.
  input  logic [deft_pkg::InDataW-1:0]  s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // Fields from bit 0: message_seen[0], param_out[16:1], zero fill.
  output logic [deft_pkg::OutDataW-1:0] m_axis_tdata
);

  logic              in_valid_q, in_valid_d;
  deft_pkg::item_t   in_item_q;
  logic              out_valid_q, out_valid_d;
  deft_pkg::result_t out_result_q;
  deft_pkg::result_t result;
  logic              s_fire;
  logic              advance;

  // An item moves on when the result register is free or being emptied.
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign s_fire        = s_axis_tvalid && s_axis_tready;

  assign in_valid_d  = s_fire || (in_valid_q && !advance);
  assign out_valid_d = advance || (out_valid_q && !m_axis_tready);

  // Handshake state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      in_item_q <= deft_pkg::item_t'(s_axis_tdata[deft_pkg::InFieldsW-1:0]);
    end
    if (advance) begin
      out_result_q <= result;
    end
  end

  deft_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (advance),
    .item_i   (in_item_q),
    .result_o (result)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = deft_pkg::OutDataW'(out_result_q);

endmodule

/* verif/tb.sv */
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import deft_pkg::*;

  localparam int StallLimit   = 2000;
  localparam int DrainCycles  = 8;
  localparam int ReportLimit  = 10;

  logic                clk_i;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata  = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;

  // Shadow copy of the flag and parameter tables.
  flag_e                 msg_flag   [MsgCount];
  logic [ParamWidth-1:0] msg_param  [MsgCount];
  flag_e                 bc_flag    [BcCount];

  result_t pending_results[$];
  bit      quiet;
  int      items_sent;
  int      results_checked;
  int      seen_hits;
  int      mismatch_count;
  int      idle_cycles;
  int      op_count [8];

  delayed_event_flag_table uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // Free-running clock.
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // The tables come out of reset idle with cleared parameters.
  initial begin
    for (int i = 0; i < MsgCount; i++) begin
      msg_flag[i]  = FlagIdle;
      msg_param[i] = '0;
    end
    for (int i = 0; i < BcCount; i++) begin
      bc_flag[i] = FlagIdle;
    end
  end

  // One tick step of a flag: posted turns visible, visible expires, others stay.
  function automatic flag_e tick_step(flag_e f);
    if (f == FlagPosted) begin
      return FlagVisible;
    end else if (f == FlagVisible) begin
      return FlagIdle;
    end
    return f;
  endfunction

  // Applies one operation to the shadow tables and returns the result it produces.
  function automatic result_t apply_flag_op(item_t it);
    result_t res;
    int      idx;
    bit      msg_ok;
    bit      bc_ok;
    res    = '0;
    idx    = int'(it.message_index);
    msg_ok = idx < MsgCount;
    bc_ok  = idx < BcCount;
    case (it.operation)
      OpSend, OpSendParam: begin
        if (msg_ok && msg_flag[idx] == FlagIdle) begin
          msg_flag[idx] = FlagPosted;
          if (it.operation == OpSendParam) begin
            msg_param[idx] = ParamWidth'(it.param_in);
          end
        end
      end
      OpGet: begin
        if (msg_ok && msg_flag[idx] == FlagVisible) begin
          msg_flag[idx]    = FlagIdle;
          res.message_seen = 1'b1;
        end
      end
      OpReadParam: begin
        if (msg_ok) begin
          res.param_out = ParamOutWidth'(msg_param[idx]);
        end
      end
      OpTick: begin
        for (int i = 0; i < MsgCount; i++) begin
          msg_flag[i] = tick_step(msg_flag[i]);
        end
        for (int i = 0; i < BcCount; i++) begin
          bc_flag[i] = tick_step(bc_flag[i]);
        end
      end
      OpBcSend: begin
        if (bc_ok && bc_flag[idx] == FlagIdle) begin
          bc_flag[idx] = FlagPosted;
        end
      end
      OpBcGet: begin
        // Broadcast get reports but does not consume.
        if (bc_ok && bc_flag[idx] == FlagVisible) begin
          res.message_seen = 1'b1;
        end
      end
      default: begin
        // Clear drops every flag but keeps the stored parameters.
        for (int i = 0; i < MsgCount; i++) begin
          msg_flag[i] = FlagIdle;
        end
        for (int i = 0; i < BcCount; i++) begin
          bc_flag[i] = FlagIdle;
        end
      end
    endcase
    return res;
  endfunction

  // Gap length: mostly none or short, now and then long, none at all when quiet.
  function automatic int pick_gap();
    int r;
    if (quiet) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 50) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(4, 30);
  endfunction

  function automatic void note_mismatch(string what, result_t want, result_t got);
    mismatch_count++;
    if (mismatch_count <= ReportLimit) begin
      $display("%0t: %s: expected seen=%0b param=%h, actual seen=%0b param=%h", $realtime,
               what, want.message_seen, want.param_out, got.message_seen, got.param_out);
    end
  endfunction

  // Offers one item after a random gap and records its expected result on transfer.
  task automatic send_item(input op_e op, input int idx, input logic [ParamInWidth-1:0] param);
    item_t it;
    int    gap;
    it.operation     = op;
    it.message_index = IndexWidth'(idx);
    it.param_in      = param;
    gap = pick_gap();
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= InDataW'(it);
    do @(posedge clk_i); while (!s_axis_tready);
    pending_results.push_back(apply_flag_op(it));
    items_sent++;
    op_count[int'(op)]++;
  endtask

  task automatic send_random(input bit allow_clear);
    op_e op;
    op = op_e'($urandom_range(0, allow_clear ? 7 : 6));
    send_item(op, $urandom_range(0, 15), ParamInWidth'($urandom));
  endtask

  // Posting, reading and consuming message entries, including repeated sends.
  task automatic test_message_post_and_get();
    send_item(OpReadParam, 0, 16'hFFFF);
    send_item(OpReadParam, 15, 16'h0000);
    send_item(OpSendParam, 0, 16'hFFFF);
    send_item(OpSendParam, 15, 16'h0000);
    send_item(OpSendParam, 0, 16'h1234);
    send_item(OpSend, 5, 16'hAAAA);
    send_item(OpGet, 0, 16'h0000);
    send_item(OpTick, 0, 16'h0000);
    send_item(OpGet, 0, 16'h0000);
    send_item(OpGet, 0, 16'h0000);
    send_item(OpReadParam, 0, 16'h0000);
  endtask

  // Broadcast entries stay visible across gets; indexes past the table are dropped.
  task automatic test_broadcast();
    send_item(OpBcSend, 7, 16'h0000);
    send_item(OpBcSend, 8, 16'h0000);
    send_item(OpTick, 9, 16'h0000);
    send_item(OpBcGet, 7, 16'h0000);
    send_item(OpBcGet, 7, 16'h0000);
    send_item(OpBcGet, 8, 16'h0000);
    send_item(OpTick, 0, 16'h0000);
    send_item(OpBcGet, 7, 16'h0000);
  endtask

  // Flags that expire unread, and clear-all keeping stored parameters.
  task automatic test_expiry_and_clear();
    send_item(OpSend, 3, 16'h0000);
    send_item(OpTick, 0, 16'h0000);
    send_item(OpTick, 0, 16'h0000);
    send_item(OpGet, 3, 16'h0000);
    send_item(OpSend, 1, 16'h0000);
    send_item(OpBcSend, 0, 16'h0000);
    send_item(OpClear, 15, 16'hFFFF);
    send_item(OpTick, 0, 16'h0000);
    send_item(OpGet, 1, 16'h0000);
    send_item(OpBcGet, 0, 16'h0000);
    send_item(OpReadParam, 0, 16'h0000);
  endtask

  // Send, tick and get sequences on one entry with random traffic woven in.
  task automatic test_random_post_get_sequences(input int count);
    int  stop_at;
    int  idx;
    bit  bcast;
    stop_at = items_sent + count;
    while (items_sent < stop_at) begin
      if ($urandom_range(0, 19) == 0) begin
        quiet = !quiet;
      end
      idx   = $urandom_range(0, 15);
      bcast = $urandom_range(0, 9) < 3;
      if (bcast) begin
        send_item(OpBcSend, idx, ParamInWidth'($urandom));
      end else begin
        send_item($urandom_range(0, 1) ? OpSendParam : OpSend, idx, ParamInWidth'($urandom));
      end
      repeat ($urandom_range(0, 2)) send_random(1'b0);
      send_item(OpTick, $urandom_range(0, 15), ParamInWidth'($urandom));
      if ($urandom_range(0, 6) == 0) begin
        send_item(OpTick, $urandom_range(0, 15), ParamInWidth'($urandom));
      end
      repeat ($urandom_range(0, 2)) send_random(1'b0);
      if ($urandom_range(0, 9) < 8) begin
        send_item(bcast ? OpBcGet : OpGet, idx, ParamInWidth'($urandom));
      end
      if ($urandom_range(0, 2) == 0) begin
        send_item(bcast ? OpBcGet : OpReadParam, idx, ParamInWidth'($urandom));
      end
    end
    quiet = 1'b0;
  endtask

  // Unstructured operations, clears included.
  task automatic test_random_noise(input int count);
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 29) == 0) begin
        quiet = !quiet;
      end
      send_random(1'b1);
    end
    quiet = 1'b0;
  endtask

  // Result side stalls in runs of random length.
  initial begin
    int n;
    wait (rst_ni);
    forever begin
      n = pick_gap();
      if (n != 0) begin
        m_axis_tready <= 1'b0;
        repeat (n) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
  end

  // Compare every result transfer with the oldest expectation.
  always @(posedge clk_i) begin : check_results
    result_t got;
    result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = result_t'(m_axis_tdata[OutFieldsW-1:0]);
      if (pending_results.size() == 0) begin
        note_mismatch("result with nothing expected", '0, got);
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        if (got.message_seen) begin
          seen_hits++;
        end
        if (got.message_seen !== want.message_seen || got.param_out !== want.param_out) begin
          note_mismatch("result mismatch", want, got);
        end
      end
    end
  end

  // Ends the run if neither side moves a transfer for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= StallLimit) begin
      $display("Timeout: no transfer for %0d cycles, %0d results outstanding",
               idle_cycles, pending_results.size());
      $display("RESULT: ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_message_post_and_get();
    test_broadcast();
    test_expiry_and_clear();
    test_random_post_get_sequences(1340);
    test_random_noise(480);
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    while (pending_results.size() != 0) begin
      note_mismatch("expected result never arrived", pending_results.pop_front(), '0);
    end
    $display("Sent %0d items and checked %0d results, %0d of which reported a visible flag.",
             items_sent, results_checked, seen_hits);
    $display({"Mix: send %0d, send+param %0d, get %0d, read %0d, tick %0d, ",
              "bsend %0d, bget %0d, clear %0d"},
             op_count[0], op_count[1], op_count[2], op_count[3], op_count[4], op_count[5],
             op_count[6], op_count[7]);
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
